[rtl/core/ssdo_pkg.sv]
package ssdo_pkg;

	localparam int unsigned NUM_CH    = 2;
	localparam int unsigned DELAY_W   = 16;
	localparam int unsigned APB_AW    = 3;
	localparam int unsigned APB_DW    = 32;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_PERMIT  = 2'd1;
	localparam logic [1:0] OP_REQUEST = 2'd2;

	localparam logic REG_DELAY_CH0 = 1'b0;
	localparam logic REG_DELAY_CH1 = 1'b1;

	typedef enum logic [1:0] {
		MODE_SAFE  = 2'd0,
		MODE_HIGH  = 2'd1,
		MODE_DELAY = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} ctl_state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ssdo_cmd_t;

endpackage

[rtl/core/ssdo_cfg.sv]
module ssdo_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssdo_pkg::APB_AW-1:0]   paddr,
	input  logic [ssdo_pkg::APB_DW-1:0]   pwdata,
	output logic [ssdo_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output logic [ssdo_pkg::DELAY_W-1:0]  delay_ch0,
	output logic [ssdo_pkg::DELAY_W-1:0]  delay_ch1
);
	import ssdo_pkg::*;

	logic                wr_en;
	logic                reg_sel;
	logic [DELAY_W-1:0]  delay_ch0_q;
	logic [DELAY_W-1:0]  delay_ch1_q;

	// Registers sit on word boundaries; only the word select bit decodes.
	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ch0_q <= '0;
			delay_ch1_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_DELAY_CH0: delay_ch0_q <= pwdata[DELAY_W-1:0];
				REG_DELAY_CH1: delay_ch1_q <= pwdata[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_DELAY_CH0: prdata = {{(APB_DW-DELAY_W){1'b0}}, delay_ch0_q};
			REG_DELAY_CH1: prdata = {{(APB_DW-DELAY_W){1'b0}}, delay_ch1_q};
			default:       prdata = '0;
		endcase
	end

	assign delay_ch0 = delay_ch0_q;
	assign delay_ch1 = delay_ch1_q;

endmodule

[rtl/core/ssdo_ctrl.sv]
module ssdo_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output ssdo_pkg::ssdo_cmd_t cmd
);
	import ssdo_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign cmd.capture = start & (state_q == ST_IDLE);
	assign cmd.execute = (state_q == ST_EXEC);

endmodule

[rtl/core/ssdo_dpath.sv]
module ssdo_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssdo_pkg::ssdo_cmd_t           cmd,
	input  logic [1:0]                    op,
	input  logic                          channel,
	input  logic                          partner_channel,
	input  logic                          request_high,
	input  logic                          permit_value,
	input  logic                          fault_channel,
	input  logic                          fault_partner,
	input  logic [ssdo_pkg::DELAY_W-1:0]  delay_ch0,
	input  logic [ssdo_pkg::DELAY_W-1:0]  delay_ch1,
	output logic                          done,
	output logic                          drive_update,
	output logic                          drive_level,
	output logic [1:0]                    ramp_flags
);
	import ssdo_pkg::*;

	// Item fields held for the execute cycle.
	logic [1:0]          op_q;
	logic                ch_q;
	logic                pc_q;
	logic                req_high_q;
	logic                pval_q;
	logic                fault_q;

	// Per-channel state.
	mode_t               mode_q   [NUM_CH];
	logic [DELAY_W-1:0]  timer_q  [NUM_CH];
	logic [NUM_CH-1:0]   permit_q;

	mode_t               mode_d   [NUM_CH];
	logic [DELAY_W-1:0]  timer_d  [NUM_CH];
	logic [NUM_CH-1:0]   permit_d;

	logic                permits;
	logic [DELAY_W-1:0]  dly;
	logic                upd;
	logic                lvl;
	logic [1:0]          ramp;

	logic                done_q;
	logic                upd_q;
	logic                lvl_q;
	logic [1:0]          ramp_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= op;
			ch_q       <= channel;
			pc_q       <= partner_channel;
			req_high_q <= request_high;
			pval_q     <= permit_value;
			fault_q    <= fault_channel | fault_partner;
		end
	end

	assign permits = permit_q[ch_q] & permit_q[pc_q];
	assign dly     = ch_q ? delay_ch1 : delay_ch0;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			mode_d[i]  = mode_q[i];
			timer_d[i] = timer_q[i];
		end
		permit_d = permit_q;
		upd      = 1'b0;
		lvl      = 1'b0;
		unique case (op_q)
			OP_TICK: begin
				for (int i = 0; i < NUM_CH; i++) begin
					if (timer_q[i] != '0) begin
						timer_d[i] = timer_q[i] - DELAY_W'(1);
					end
				end
			end
			OP_PERMIT: permit_d[ch_q] = pval_q;
			OP_REQUEST: begin
				unique case (mode_q[ch_q])
					MODE_HIGH: begin
						if (!req_high_q) begin
							if (!fault_q && permits && (dly != '0)) begin
								mode_d[ch_q]  = MODE_DELAY;
								mode_d[pc_q]  = MODE_DELAY;
								timer_d[ch_q] = dly;
								timer_d[pc_q] = dly;
							end else begin
								upd          = 1'b1;
								mode_d[ch_q] = MODE_SAFE;
								mode_d[pc_q] = MODE_SAFE;
							end
						end else if (!permits) begin
							upd          = 1'b1;
							mode_d[ch_q] = MODE_SAFE;
							mode_d[pc_q] = MODE_SAFE;
						end
					end
					MODE_DELAY: begin
						if (req_high_q) begin
							// A new high request cancels the stop delay either way.
							upd           = 1'b1;
							lvl           = permits;
							mode_d[ch_q]  = permits ? MODE_HIGH : MODE_SAFE;
							mode_d[pc_q]  = permits ? MODE_HIGH : MODE_SAFE;
							timer_d[ch_q] = '0;
							timer_d[pc_q] = '0;
						end else if (fault_q || !permits ||
						             ((timer_q[ch_q] == '0) && (timer_q[pc_q] == '0))) begin
							upd          = 1'b1;
							mode_d[ch_q] = MODE_SAFE;
							mode_d[pc_q] = MODE_SAFE;
						end
					end
					default: begin
						if (req_high_q && permits) begin
							upd          = 1'b1;
							lvl          = 1'b1;
							mode_d[ch_q] = MODE_HIGH;
							mode_d[pc_q] = MODE_HIGH;
						end
					end
				endcase
			end
			default: ;
		endcase
		for (int i = 0; i < NUM_CH; i++) begin
			ramp[i] = (mode_d[i] == MODE_DELAY);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				mode_q[i]  <= MODE_SAFE;
				timer_q[i] <= '0;
			end
			permit_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.execute;
			if (cmd.execute) begin
				for (int i = 0; i < NUM_CH; i++) begin
					mode_q[i]  <= mode_d[i];
					timer_q[i] <= timer_d[i];
				end
				permit_q <= permit_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			upd_q  <= upd;
			lvl_q  <= upd & lvl;
			ramp_q <= ramp;
		end
	end

	assign done         = done_q;
	assign drive_update = upd_q;
	assign drive_level  = lvl_q;
	assign ramp_flags   = ramp_q;

endmodule

[rtl/core/safe_stop_delay_output_controller_core.sv]
// Safe-stop output controller for two channels with a timed stop delay.
// Items enter on a command port: an item is taken at a clock edge where
// start is high and busy is low. op selects a timer tick, a permit bit
// write or an output request for channel and partner_channel.
// Each item yields exactly one result, shown on drive_update, drive_level
// and ramp_flags for one cycle while done is high. There is no result
// back-pressure; the receiver must take every result in that cycle.
// Each item is captured first, then the mode, timer and permit registers
// are updated from it; no new item is accepted until that update is done.
// busy is high only during the update cycle.
// The stop delays delay_ch0 and delay_ch1 sit at byte addresses 0 and 4 of
// the APB port; write them only while no item is in flight.
// Reset puts both channels in the safe mode, clears timers, permits and
// both delay registers, and leaves the block ready for an item at once.
module safe_stop_delay_output_controller_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic                         channel,
	input  logic                         partner_channel,
	input  logic                         request_high,
	input  logic                         permit_value,
	input  logic                         fault_channel,
	input  logic                         fault_partner,
	output logic                         done,
	output logic                         drive_update,
	output logic                         drive_level,
	output logic [1:0]                   ramp_flags,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ssdo_pkg::APB_AW-1:0]  paddr,
	input  logic [ssdo_pkg::APB_DW-1:0]  pwdata,
	output logic [ssdo_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);
	import ssdo_pkg::*;

	ssdo_cmd_t           cmd;
	logic [DELAY_W-1:0]  delay_ch0;
	logic [DELAY_W-1:0]  delay_ch1;

	ssdo_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.delay_ch0 (delay_ch0),
		.delay_ch1 (delay_ch1)
	);

	ssdo_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	ssdo_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.op              (op),
		.channel         (channel),
		.partner_channel (partner_channel),
		.request_high    (request_high),
		.permit_value    (permit_value),
		.fault_channel   (fault_channel),
		.fault_partner   (fault_partner),
		.delay_ch0       (delay_ch0),
		.delay_ch1       (delay_ch1),
		.done            (done),
		.drive_update    (drive_update),
		.drive_level     (drive_level),
		.ramp_flags      (ramp_flags)
	);

endmodule
